// File: rtl/core/round_robin_wait_time_defines.svh
// assertion macros for the round-robin wait time block
// no dependencies; included by modules that carry assertions
`ifndef ROUND_ROBIN_WAIT_TIME_DEFINES_SVH
`define ROUND_ROBIN_WAIT_TIME_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on the rising clock edge, held off while reset is low
`define RRWT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every rising clock edge, reset included
`define RRWT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRWT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRWT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/rrwt_pkg.sv
// shared constants, types and unit opcodes for the round-robin wait time block
// no dependencies
package rrwt_pkg;

  localparam int MAX_PROCS = 16;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int BURST_W   = 16;
  localparam int CLK_W     = 20;
  localparam int TOT_W     = 24;
  localparam int PIDX_W    = 4;
  localparam int ALU_W     = 24;

  localparam logic [ALU_W-1:0] CLK_MAX = ALU_W'((1 << CLK_W) - 1);
  localparam logic [ALU_W-1:0] TOT_MAX = ALU_W'((1 << TOT_W) - 1);

  typedef enum logic [1:0] {
    ALU_ADD_CLK = 2'd0,
    ALU_ADD_TOT = 2'd1,
    ALU_SUB     = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [BURST_W-1:0] burst_time;
    logic               last_process;
  } load_t;

  typedef struct packed {
    logic [PIDX_W-1:0] process_index;
    logic [CLK_W-1:0]  proc_wait;
    logic [CLK_W-1:0]  turnaround_time;
    logic [TOT_W-1:0]  total_waiting;
    logic [TOT_W-1:0]  total_turnaround;
    logic              last_result;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_push_t;

endpackage

// File: rtl/core/rrwt_if.sv
// valid/ready channel interfaces for the load and result sides
// depends on rrwt_pkg
interface rrwt_in_if import rrwt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BURST_W-1:0] burst_time;
  logic               last_process;

  modport source (output valid, output burst_time, output last_process, input ready);
  modport sink   (input valid, input burst_time, input last_process, output ready);
endinterface

interface rrwt_out_if import rrwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIDX_W-1:0] process_index;
  logic [CLK_W-1:0]  proc_wait;
  logic [CLK_W-1:0]  turnaround_time;
  logic [TOT_W-1:0]  total_waiting;
  logic [TOT_W-1:0]  total_turnaround;
  logic              last_result;

  modport source (output valid, output process_index, output proc_wait,
                  output turnaround_time, output total_waiting,
                  output total_turnaround, output last_result, input ready);
  modport sink   (input valid, input process_index, input proc_wait,
                  input turnaround_time, input total_waiting,
                  input total_turnaround, input last_result, output ready);
endinterface

// File: rtl/core/rrwt_alu.sv
// shared unit: saturating add, wrapping subtract and compare
// depends on rrwt_pkg
module rrwt_alu import rrwt_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] y,
  output logic             gt
);

  logic [ALU_W:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};
  assign gt  = (a > b);

  always_comb begin
    unique case (op)
      ALU_ADD_CLK: y = (sum > {1'b0, CLK_MAX}) ? CLK_MAX : sum[ALU_W-1:0];
      ALU_ADD_TOT: y = sum[ALU_W] ? TOT_MAX : sum[ALU_W-1:0];
      ALU_SUB:     y = a - b;
      default:     y = '0;
    endcase
  end

endmodule

// File: rtl/core/rrwt_seq.sv
// sequencer with burst, remaining and wait stores; drives the shared unit
// depends on rrwt_pkg, rrwt_alu and the assertion macro header
`include "round_robin_wait_time_defines.svh"

module rrwt_seq import rrwt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_valid,
  output logic               load_ready,
  input  load_t              load_data,
  input  logic [BURST_W-1:0] quantum,
  input  logic               res_room,
  output res_push_t          push
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_SIM_RD   = 10'b00_0000_0010,
    S_SIM_CMP  = 10'b00_0000_0100,
    S_SIM_CLK  = 10'b00_0000_1000,
    S_SIM_WAIT = 10'b00_0001_0000,
    S_EM_RD    = 10'b00_0010_0000,
    S_EM_TURN  = 10'b00_0100_0000,
    S_EM_TW    = 10'b00_1000_0000,
    S_EM_TT    = 10'b01_0000_0000,
    S_EM_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   loaded_r, loaded_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic               busy_r, busy_nxt;
  logic               gt_r, gt_nxt;
  logic [BURST_W-1:0] diff_r, diff_nxt;
  logic [CLK_W-1:0]   elapsed_r, elapsed_nxt;
  logic [CLK_W-1:0]   turn_r, turn_nxt;
  logic [TOT_W-1:0]   totw_r, totw_nxt;
  logic [TOT_W-1:0]   tott_r, tott_nxt;

  logic [BURST_W-1:0] burst_mem [MAX_PROCS];
  logic [BURST_W-1:0] rem_mem   [MAX_PROCS];
  logic [CLK_W-1:0]   wait_mem  [MAX_PROCS];
  logic [BURST_W-1:0] burst_q, rem_q;
  logic [CLK_W-1:0]   wait_q;

  logic               rd_en, burst_we, rem_we, wait_we;
  logic [IDX_W-1:0]   w_idx;
  logic [BURST_W-1:0] rem_wd;
  logic [CLK_W-1:0]   wait_wd;
  logic [CNT_W-1:0]   cnt_inc;
  logic               full;

  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_gt;

  rrwt_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .gt (alu_gt)
  );

  assign full       = (loaded_r >= CNT_W'(MAX_PROCS));
  assign cnt_inc    = full ? loaded_r : CNT_W'(loaded_r + CNT_W'(1));
  assign load_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    loaded_nxt  = loaded_r;
    n_nxt       = n_r;
    i_nxt       = i_r;
    busy_nxt    = busy_r;
    gt_nxt      = gt_r;
    diff_nxt    = diff_r;
    elapsed_nxt = elapsed_r;
    turn_nxt    = turn_r;
    totw_nxt    = totw_r;
    tott_nxt    = tott_r;
    rd_en       = 1'b0;
    burst_we    = 1'b0;
    rem_we      = 1'b0;
    wait_we     = 1'b0;
    w_idx       = i_r[IDX_W-1:0];
    rem_wd      = diff_r;
    wait_wd     = alu_y[CLK_W-1:0];
    alu_op      = ALU_ADD_TOT;
    alu_a       = '0;
    alu_b       = '0;
    push.valid  = 1'b0;

    push.res.process_index    = PIDX_W'(i_r);
    push.res.proc_wait        = wait_q;
    push.res.turnaround_time  = turn_r;
    push.res.total_waiting    = totw_r;
    push.res.total_turnaround = tott_r;
    push.res.last_result      = (CNT_W'(i_r + CNT_W'(1)) == n_r);

    unique case (state_r)
      S_IDLE: begin
        if (load_valid) begin
          // loading also primes remaining and clears the wait entry
          if (!full) begin
            burst_we   = 1'b1;
            rem_we     = 1'b1;
            wait_we    = 1'b1;
            w_idx      = loaded_r[IDX_W-1:0];
            rem_wd     = load_data.burst_time;
            wait_wd    = '0;
            loaded_nxt = cnt_inc;
          end
          if (load_data.last_process) begin
            n_nxt       = cnt_inc;
            i_nxt       = '0;
            busy_nxt    = 1'b0;
            elapsed_nxt = '0;
            totw_nxt    = '0;
            tott_nxt    = '0;
            state_nxt   = S_SIM_RD;
          end
        end
      end
      S_SIM_RD: begin
        if (i_r == n_r) begin
          i_nxt    = '0;
          busy_nxt = 1'b0;
          if (!busy_r) begin
            state_nxt = S_EM_RD;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_SIM_CMP;
        end
      end
      S_SIM_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(rem_q);
        alu_b  = ALU_W'(quantum);
        if (rem_q == '0) begin
          i_nxt     = CNT_W'(i_r + CNT_W'(1));
          state_nxt = S_SIM_RD;
        end else begin
          gt_nxt    = alu_gt;
          diff_nxt  = alu_y[BURST_W-1:0];
          busy_nxt  = 1'b1;
          state_nxt = S_SIM_CLK;
        end
      end
      S_SIM_CLK: begin
        alu_op      = ALU_ADD_CLK;
        alu_a       = ALU_W'(elapsed_r);
        alu_b       = gt_r ? ALU_W'(quantum) : ALU_W'(rem_q);
        elapsed_nxt = alu_y[CLK_W-1:0];
        if (gt_r) begin
          rem_we    = 1'b1;
          i_nxt     = CNT_W'(i_r + CNT_W'(1));
          state_nxt = S_SIM_RD;
        end else begin
          state_nxt = S_SIM_WAIT;
        end
      end
      S_SIM_WAIT: begin
        // process done: wait is completion time minus burst
        alu_op    = ALU_SUB;
        alu_a     = ALU_W'(elapsed_r);
        alu_b     = ALU_W'(burst_q);
        wait_we   = 1'b1;
        rem_we    = 1'b1;
        rem_wd    = '0;
        i_nxt     = CNT_W'(i_r + CNT_W'(1));
        state_nxt = S_SIM_RD;
      end
      S_EM_RD: begin
        if (i_r == n_r) begin
          loaded_nxt = '0;
          state_nxt  = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_EM_TURN;
        end
      end
      S_EM_TURN: begin
        alu_op    = ALU_ADD_CLK;
        alu_a     = ALU_W'(burst_q);
        alu_b     = ALU_W'(wait_q);
        turn_nxt  = alu_y[CLK_W-1:0];
        state_nxt = S_EM_TW;
      end
      S_EM_TW: begin
        alu_op    = ALU_ADD_TOT;
        alu_a     = ALU_W'(totw_r);
        alu_b     = ALU_W'(wait_q);
        totw_nxt  = alu_y[TOT_W-1:0];
        state_nxt = S_EM_TT;
      end
      S_EM_TT: begin
        alu_op    = ALU_ADD_TOT;
        alu_a     = ALU_W'(tott_r);
        alu_b     = ALU_W'(turn_r);
        tott_nxt  = alu_y[TOT_W-1:0];
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        push.valid = 1'b1;
        if (res_room) begin
          i_nxt     = CNT_W'(i_r + CNT_W'(1));
          state_nxt = S_EM_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      loaded_r  <= '0;
      n_r       <= '0;
      i_r       <= '0;
      busy_r    <= 1'b0;
      elapsed_r <= '0;
    end else begin
      state_r   <= state_nxt;
      loaded_r  <= loaded_nxt;
      n_r       <= n_nxt;
      i_r       <= i_nxt;
      busy_r    <= busy_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gt_r   <= gt_nxt;
    diff_r <= diff_nxt;
    turn_r <= turn_nxt;
    totw_r <= totw_nxt;
    tott_r <= tott_nxt;
  end

  // stores: one write port each, registered read at the current process
  always_ff @(posedge clk) begin
    if (burst_we) begin
      burst_mem[w_idx] <= load_data.burst_time;
    end
    if (rem_we) begin
      rem_mem[w_idx] <= rem_wd;
    end
    if (wait_we) begin
      wait_mem[w_idx] <= wait_wd;
    end
    if (rd_en) begin
      burst_q <= burst_mem[i_r[IDX_W-1:0]];
      rem_q   <= rem_mem[i_r[IDX_W-1:0]];
      wait_q  <= wait_mem[i_r[IDX_W-1:0]];
    end
  end

  `RRWT_ASSERT(a_load_bound, clk, rst_n, loaded_r <= CNT_W'(MAX_PROCS),
               "loaded count above store depth")
  `RRWT_ASSERT(a_sim_idx, clk, rst_n, (state_r == S_SIM_CLK) |-> (i_r < n_r),
               "simulation step beyond loaded set")
  `RRWT_ASSERT(a_clk_mono, clk, rst_n,
               (state_r == S_SIM_CLK) |=> (elapsed_r >= $past(elapsed_r)),
               "elapsed clock went backwards")
  `RRWT_ASSERT(a_done_clear, clk, rst_n,
               (state_r == S_EM_RD && i_r == n_r) |=> (state_r == S_IDLE && loaded_r == '0),
               "batch end did not empty the store")
  `RRWT_ASSERT(a_push_adv, clk, rst_n,
               (state_r == S_EM_OUT && res_room) |=> (state_r == S_EM_RD),
               "result transfer did not advance")

endmodule

// File: rtl/core/round_robin_wait_time.sv
// round-robin wait time block: quantum register, output register, sequencer
// depends on rrwt_pkg, rrwt_if and rrwt_seq
//
// usage:
//   in_ch carries one burst_time per transfer; last_process closes the batch
//   (up to 16 processes, extra bursts are dropped but a last still starts).
//   cfg_we/cfg_wdata write the quantum (reset 4, zero acts as 1), which the user
//   must do only while idle, unchecked by the block. out_ch returns one result
//   per loaded process in load order, the final one flagged with last_result.
// timing:
//   in_ch.ready stays high for non-last bursts and is low from the last burst
//   until the final result is in the output register and the sequencer is idle.
//   a simulation pass reads and compares each process in turn; a slice then
//   advances the clock and writes remaining back, a final slice also its wait;
//   an index check ends the pass. all share the single add/compare unit and the
//   one-port stores. each result takes a store read, three unit steps and a push.
// reset: synchronous, active low; clears the sequencer and output valid,
//   sets the quantum to 4; store contents are rewritten by each load.
// stall: a held out_ch.ready keeps the result in the output register and
//   the sequencer waits with the next result; nothing is lost.
module round_robin_wait_time import rrwt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [BURST_W-1:0] cfg_wdata,
  rrwt_in_if.sink            in_ch,
  rrwt_out_if.source         out_ch
);

  logic [BURST_W-1:0] quantum_r;
  logic [BURST_W-1:0] quantum_eff;
  logic               out_valid_r;
  res_t               out_data_r;
  logic               res_room;
  load_t              load_data;
  res_push_t          push;

  assign quantum_eff = (quantum_r == '0) ? BURST_W'(1) : quantum_r;
  assign res_room    = !out_valid_r || out_ch.ready;

  assign load_data.burst_time   = in_ch.burst_time;
  assign load_data.last_process = in_ch.last_process;

  rrwt_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_ch.valid),
    .load_ready (in_ch.ready),
    .load_data  (load_data),
    .quantum    (quantum_eff),
    .res_room   (res_room),
    .push       (push)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= BURST_W'(4);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      if (push.valid && res_room) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && res_room) begin
      out_data_r <= push.res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.process_index    = out_data_r.process_index;
  assign out_ch.proc_wait        = out_data_r.proc_wait;
  assign out_ch.turnaround_time  = out_data_r.turnaround_time;
  assign out_ch.total_waiting    = out_data_r.total_waiting;
  assign out_ch.total_turnaround = out_data_r.total_turnaround;
  assign out_ch.last_result      = out_data_r.last_result;

endmodule
